FILE: sv/x86af_pkg.sv
// Shared types and constants for the x86 ALU flag unit.
`default_nettype none

package x86af_pkg;

    localparam int unsigned PORT_W = 32;

    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_CMP  = 3'd1,
        CMD_INC  = 3'd2,
        CMD_DEC  = 3'd3,
        CMD_MUL  = 3'd4,
        CMD_IMUL = 3'd5
    } cmd_t;

    // bit 0 CF, bit 1 ZF, bit 2 SF, bit 3 OF, bit 4 AF, bit 5 PF
    typedef struct packed {
        logic pf;
        logic af;
        logic of;
        logic sf;
        logic zf;
        logic cf;
    } flags_t;

    typedef struct packed {
        logic [PORT_W-1:0] value_lo;
        logic [PORT_W-1:0] value_hi;
        logic              written;
        flags_t            flags;
    } alu_res_t;

endpackage

`default_nettype wire

FILE: sv/x86af_alu.sv
// Combinational datapath: add, compare, inc, dec, mul and imul with flag update.
`default_nettype none

module x86af_alu
    import x86af_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic [2:0]        command,
    input  wire logic [PORT_W-1:0] operand_a,
    input  wire logic [PORT_W-1:0] operand_b,
    input  wire flags_t            flags_in,
    output alu_res_t               res
);

    localparam int unsigned DW = DATA_WIDTH;
    localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MIN_NEG = {1'b1, {(DW-1){1'b0}}};

    logic [DW-1:0]          a;
    logic [DW-1:0]          b;
    logic [DW:0]            sum;
    logic [DW:0]            diff;
    logic [DW-1:0]          inc_val;
    logic [DW-1:0]          dec_val;
    logic                   mul_signed;
    logic [DW:0]            ax;
    logic [DW:0]            bx;
    logic signed [2*DW+1:0] prod;
    logic [DW-1:0]          prod_lo;
    logic [DW-1:0]          prod_hi;
    logic                   imul_fits;
    logic [DW-1:0]          lo;
    logic [DW-1:0]          hi;
    logic                   wr;
    flags_t                 f;

    assign a       = operand_a[DW-1:0];
    assign b       = operand_b[DW-1:0];
    assign sum     = {1'b0, a} + {1'b0, b};
    assign diff    = {1'b0, a} - {1'b0, b};
    assign inc_val = a + DW'(1);
    assign dec_val = a - DW'(1);

    // One signed multiplier one bit wider serves both mul and imul.
    assign mul_signed = (command == CMD_IMUL);
    assign ax         = {mul_signed & a[DW-1], a};
    assign bx         = {mul_signed & b[DW-1], b};
    assign prod       = $signed(ax) * $signed(bx);
    assign prod_lo    = prod[DW-1:0];
    assign prod_hi    = prod[2*DW-1:DW];
    assign imul_fits  = prod_lo[DW-1] ? (prod_hi == {DW{1'b1}}) : (prod_hi == '0);

    always_comb begin
        lo = '0;
        hi = '0;
        wr = 1'b0;
        f  = flags_in;
        unique case (cmd_t'(command))
            CMD_ADD: begin
                lo   = sum[DW-1:0];
                wr   = 1'b1;
                f.zf = (sum[DW-1:0] == '0);
                f.sf = sum[DW-1];
                f.cf = sum[DW];
            end
            CMD_CMP: begin
                f.zf = (diff[DW-1:0] == '0);
                f.sf = diff[DW-1];
                f.pf = ~^diff[7:0];
                f.cf = diff[DW];
                f.of = (a[DW-1] != b[DW-1]) && (a[DW-1] != diff[DW-1]);
                f.af = (a[3:0] < b[3:0]);
            end
            CMD_INC: begin
                lo   = inc_val;
                wr   = 1'b1;
                f.zf = (inc_val == '0);
                f.sf = inc_val[DW-1];
                f.pf = ~^inc_val[7:0];
                f.of = (a == MAX_POS);
                f.af = (a[3:0] == 4'hF);
            end
            CMD_DEC: begin
                lo   = dec_val;
                wr   = 1'b1;
                f.zf = (dec_val == '0);
                f.sf = dec_val[DW-1];
                f.pf = ~^dec_val[7:0];
                f.of = (a == MIN_NEG);
                f.af = (a[3:0] == 4'h0);
            end
            CMD_MUL: begin
                lo   = prod_lo;
                hi   = prod_hi;
                wr   = 1'b1;
                f.cf = (prod_hi != '0);
                f.of = (prod_hi != '0);
            end
            CMD_IMUL: begin
                lo   = prod_lo;
                hi   = prod_hi;
                wr   = 1'b1;
                f.cf = ~imul_fits;
                f.of = ~imul_fits;
            end
            default: begin
                // unused codes: hold the flags, write nothing
                lo = '0;
            end
        endcase
    end

    assign res.value_lo = PORT_W'(lo);
    assign res.value_hi = PORT_W'(hi);
    assign res.written  = wr;
    assign res.flags    = f;

endmodule

`default_nettype wire

FILE: sv/x86_alu_flag_unit_top.sv
// Top level of the x86 ALU flag unit: input register, datapath, result register.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | command, operand_a, operand_b
//  m_      | out       | m_valid / m_ready    | value_lo/hi, result_written, six flags
//
// One beat per cycle while m_ready stays high; a beat passes the input register, then
// the result register, before m_valid rises. The input register holds the beat, the
// datapath (add, subtract, inc, dec and one 33x33 multiply) forms the result and the
// next flags, which load the result register and the flag register together. Reset empties both
// stages and clears all six flags. A stall on m_ready holds the result and the flags;
// one more beat is still taken into the input register.
`default_nettype none

module x86_alu_flag_unit_top
    import x86af_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [2:0]        s_command,
    input  wire logic [PORT_W-1:0] s_operand_a,
    input  wire logic [PORT_W-1:0] s_operand_b,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [PORT_W-1:0]      m_value_lo,
    output logic [PORT_W-1:0]      m_value_hi,
    output logic                   m_result_written,
    output logic                   m_carry_flag,
    output logic                   m_zero_flag,
    output logic                   m_sign_flag,
    output logic                   m_overflow_flag,
    output logic                   m_adjust_flag,
    output logic                   m_parity_flag
);

    logic              in_valid_reg;
    logic [2:0]        in_cmd_reg;
    logic [PORT_W-1:0] in_a_reg;
    logic [PORT_W-1:0] in_b_reg;
    logic              out_valid_reg;
    alu_res_t          out_reg;
    flags_t            flags_reg;
    alu_res_t          alu_res;
    logic              out_free;
    logic              advance;
    logic              s_fire;

    assign out_free = ~out_valid_reg | m_ready;
    assign advance  = in_valid_reg & out_free;
    assign s_ready  = ~in_valid_reg | out_free;
    assign s_fire   = s_valid & s_ready;

    x86af_alu #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_alu (
        .command  (in_cmd_reg),
        .operand_a(in_a_reg),
        .operand_b(in_b_reg),
        .flags_in (flags_reg),
        .res      (alu_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                flags_reg <= alu_res.flags;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg <= s_command;
            in_a_reg   <= s_operand_a;
            in_b_reg   <= s_operand_b;
        end
        if (advance) begin
            out_reg <= alu_res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_value_lo       = out_reg.value_lo;
    assign m_value_hi       = out_reg.value_hi;
    assign m_result_written = out_reg.written;
    assign m_carry_flag     = out_reg.flags.cf;
    assign m_zero_flag      = out_reg.flags.zf;
    assign m_sign_flag      = out_reg.flags.sf;
    assign m_overflow_flag  = out_reg.flags.of;
    assign m_adjust_flag    = out_reg.flags.af;
    assign m_parity_flag    = out_reg.flags.pf;

`ifndef SYNTHESIS
    // Reset empties the pipe and clears the flags.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !out_valid_reg && flags_reg == '0))
        else $error("reset did not clear pipe and flags");

    // Flags move only when a beat passes into the result register.
    a_flags_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(flags_reg))
        else $error("flags changed without a beat advancing");

    // A shown result always carries the current flag state.
    a_flags_match: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.flags == flags_reg))
        else $error("result flags differ from flag register");

    // No destination write means zero result fields.
    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.written) |->
            (out_reg.value_lo == '0 && out_reg.value_hi == '0))
        else $error("result fields nonzero without a write");
`endif

endmodule

`default_nettype wire
